### hw/rtl/box_nearest_point_query_core_defines.svh
// Assertion macros for the box nearest-point query core.
// Used by box_nearest_point_query_core.sv; expects i_clk and i_rst_n in scope.
`ifndef BOX_NEAREST_POINT_QUERY_CORE_DEFINES_SVH
`define BOX_NEAREST_POINT_QUERY_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define BNPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define BNPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bnpq_pkg.sv
// Shared types and constants for the box nearest-point query core.
// No dependencies; imported by every module of the block.
package bnpq_pkg;

    // Default coordinate width (Q16.16)
    localparam int CW_DEFAULT = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_cfg_reg;

    // Per-stage load enables handed from the pipeline control
    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
    } t_stage_ctl;

endpackage

### hw/rtl/bnpq_axis.sv
// One coordinate axis: midpoint test, bound tests, corner, clamp and distance.
// Two register stages; depends on bnpq_pkg.
module bnpq_axis
    import bnpq_pkg::*;
#(
    parameter int CW = CW_DEFAULT
) (
    input  logic                 i_clk,
    input  t_stage_ctl           i_ctl,
    input  logic signed [CW-1:0] i_p,
    input  logic signed [CW-1:0] i_lo,
    input  logic signed [CW-1:0] i_hi,
    output logic signed [CW-1:0] o_corner,
    output logic        [CW-1:0] o_dist,
    output logic signed [CW-1:0] o_surf,
    output logic                 o_outside
);

    // Stage 1: 2p > lo + hi in widened arithmetic, bound tests
    logic signed [CW+1:0] w_p2;
    logic signed [CW+1:0] w_sum;
    logic signed [CW-1:0] r_p;
    logic                 r_up;
    logic                 r_below;
    logic                 r_above;

    assign w_p2  = {i_p[CW-1], i_p, 1'b0};
    assign w_sum = {{2{i_lo[CW-1]}}, i_lo} + {{2{i_hi[CW-1]}}, i_hi};

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv1) begin
            r_p     <= i_p;
            r_up    <= (w_p2 > w_sum);
            r_below <= (i_p < i_lo);
            r_above <= (i_hi < i_p);
        end
    end

    // Stage 2: corner pick, exact distance to it, clamp
    logic signed [CW-1:0] w_corner;
    logic signed [CW:0]   w_diff;
    logic signed [CW:0]   w_mag;

    assign w_corner = r_up ? i_hi : i_lo;
    assign w_diff   = {r_p[CW-1], r_p} - {w_corner[CW-1], w_corner};
    assign w_mag    = w_diff[CW] ? -w_diff : w_diff;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv2) begin
            o_corner  <= w_corner;
            o_dist    <= w_mag[CW-1:0];
            o_outside <= r_below | r_above;
            if (r_below) begin
                o_surf <= i_lo;
            end else if (r_above) begin
                o_surf <= i_hi;
            end else begin
                o_surf <= r_p;
            end
        end
    end

endmodule

### hw/rtl/bnpq_face.sv
// Final stage: inside flag and nearest-face projection for inside points.
// One register stage feeding the output; depends on bnpq_pkg.
module bnpq_face
    import bnpq_pkg::*;
#(
    parameter int CW = CW_DEFAULT
) (
    input  logic                 i_clk,
    input  t_stage_ctl           i_ctl,
    input  logic signed [CW-1:0] i_corner [3],
    input  logic        [CW-1:0] i_dist   [3],
    input  logic signed [CW-1:0] i_surf   [3],
    input  logic        [2:0]    i_outside,
    output logic signed [CW-1:0] o_surf   [3],
    output logic signed [CW-1:0] o_corner [3],
    output logic                 o_inside
);

    // Face choice; ties go toward the later axis
    logic       w_inside;
    logic       w_x_lt_y;
    logic       w_x_lt_z;
    logic       w_y_lt_z;
    logic [2:0] w_sel;

    assign w_inside = ~|i_outside;
    assign w_x_lt_y = i_dist[0] < i_dist[1];
    assign w_x_lt_z = i_dist[0] < i_dist[2];
    assign w_y_lt_z = i_dist[1] < i_dist[2];

    always_comb begin
        w_sel = 3'b000;
        if (w_x_lt_y) begin
            if (w_x_lt_z) begin
                w_sel[0] = 1'b1;
            end else begin
                w_sel[2] = 1'b1;
            end
        end else begin
            if (w_y_lt_z) begin
                w_sel[1] = 1'b1;
            end else begin
                w_sel[2] = 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv3) begin
            o_inside <= w_inside;
            for (int k = 0; k < 3; k++) begin
                o_corner[k] <= i_corner[k];
                o_surf[k]   <= (w_inside && w_sel[k]) ? i_corner[k] : i_surf[k];
            end
        end
    end

endmodule

### hw/rtl/box_nearest_point_query_core.sv
// Top level of the box nearest-point query core: config registers, pipeline control.
// Depends on bnpq_pkg, bnpq_axis, bnpq_face and the defines header.
//
//  channel   | handshake           | payload
//  ----------+---------------------+--------------------------------------------
//  sample in | i_valid / o_ready   | i_sample_x, i_sample_y, i_sample_z
//  result    | o_valid / i_ready   | o_surface_*, o_corner_*, o_is_inside
//  config    | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One sample per cycle sustained while the output is not stalled; the path is registered in
// two axis stages and the face/output register. Each stage loads when it is empty or the stage
// after it moves, so a stall at the output backs up stage by stage without loss.
// Synchronous active-low reset clears the valid bits and the box registers.
`include "box_nearest_point_query_core_defines.svh"
module box_nearest_point_query_core
    import bnpq_pkg::*;
#(
    parameter int COORD_WIDTH = CW_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_sample_x,
    input  logic signed [COORD_WIDTH-1:0] i_sample_y,
    input  logic signed [COORD_WIDTH-1:0] i_sample_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_surface_x,
    output logic signed [COORD_WIDTH-1:0] o_surface_y,
    output logic signed [COORD_WIDTH-1:0] o_surface_z,
    output logic signed [COORD_WIDTH-1:0] o_corner_x,
    output logic signed [COORD_WIDTH-1:0] o_corner_y,
    output logic signed [COORD_WIDTH-1:0] o_corner_z,
    output logic                          o_is_inside
);

    localparam int CW = COORD_WIDTH;

    // Box registers
    logic signed [CW-1:0] r_box_min [3];
    logic signed [CW-1:0] r_box_max [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_box_min[k] <= '0;
                r_box_max[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_X: r_box_min[0] <= i_cfg_data;
                REG_MIN_Y: r_box_min[1] <= i_cfg_data;
                REG_MIN_Z: r_box_min[2] <= i_cfg_data;
                REG_MAX_X: r_box_max[0] <= i_cfg_data;
                REG_MAX_Y: r_box_max[1] <= i_cfg_data;
                REG_MAX_Z: r_box_max[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline valid bits and per-stage advance
    logic       r_v1, r_v2, r_v3;
    logic       n_v1, n_v2, n_v3;
    logic       w_rdy1, w_rdy2, w_rdy3;
    t_stage_ctl w_ctl;

    assign w_rdy3    = !r_v3 || i_ready;
    assign w_rdy2    = !r_v2 || w_rdy3;
    assign w_rdy1    = !r_v1 || w_rdy2;
    assign w_ctl     = '{adv1: w_rdy1, adv2: w_rdy2, adv3: w_rdy3};
    assign o_ready   = w_rdy1;
    assign o_valid   = r_v3;

    assign n_v1 = w_rdy1 ? i_valid : r_v1;
    assign n_v2 = w_rdy2 ? r_v1    : r_v2;
    assign n_v3 = w_rdy3 ? r_v2    : r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    // Per-axis datapath
    logic signed [CW-1:0] w_p       [3];
    logic signed [CW-1:0] w_corner  [3];
    logic        [CW-1:0] w_dist    [3];
    logic signed [CW-1:0] w_surf    [3];
    logic        [2:0]    w_outside;
    logic signed [CW-1:0] w_out_surf   [3];
    logic signed [CW-1:0] w_out_corner [3];

    assign w_p[0] = i_sample_x;
    assign w_p[1] = i_sample_y;
    assign w_p[2] = i_sample_z;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        bnpq_axis #(.CW(CW)) u_axis (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_p       (w_p[g]),
            .i_lo      (r_box_min[g]),
            .i_hi      (r_box_max[g]),
            .o_corner  (w_corner[g]),
            .o_dist    (w_dist[g]),
            .o_surf    (w_surf[g]),
            .o_outside (w_outside[g])
        );
    end

    // Face selection and output register
    bnpq_face #(.CW(CW)) u_face (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_corner  (w_corner),
        .i_dist    (w_dist),
        .i_surf    (w_surf),
        .i_outside (w_outside),
        .o_surf    (w_out_surf),
        .o_corner  (w_out_corner),
        .o_inside  (o_is_inside)
    );

    assign o_surface_x = w_out_surf[0];
    assign o_surface_y = w_out_surf[1];
    assign o_surface_z = w_out_surf[2];
    assign o_corner_x  = w_out_corner[0];
    assign o_corner_y  = w_out_corner[1];
    assign o_corner_z  = w_out_corner[2];

    // Checks
    `BNPQ_ASSERT_NXT(a_mid_hold, r_v2 && !w_rdy3, r_v2, "stage 2 item dropped under stall")
    `BNPQ_ASSERT_NXT(a_s1_hold, r_v1 && !w_rdy2, r_v1, "stage 1 item dropped under stall")
    `BNPQ_ASSERT_IMP(a_corner_x, o_valid, o_corner_x == r_box_min[0] || o_corner_x == r_box_max[0], "corner x is not a box bound")
    `BNPQ_ASSERT_IMP(a_inside_surf, o_valid && o_is_inside, (o_surface_x >= r_box_min[0]) && (o_surface_x <= r_box_max[0]) && (o_surface_y >= r_box_min[1]) && (o_surface_y <= r_box_max[1]) && (o_surface_z >= r_box_min[2]) && (o_surface_z <= r_box_max[2]), "inside result left the box")

endmodule

### verif/tb_box_nearest_point_query_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for box_nearest_point_query_core: surface point, corner, inside flag.
// Depends on bnpq_pkg and the core RTL; a small predictor class keeps the expected results.
module tb_box_nearest_point_query_core
    import bnpq_pkg::*;
();

    localparam int COORD_W = CW_DEFAULT;
    localparam int CLK_PERIOD = 20;
    localparam int RAND_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 235;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef t_coord t_coord3 [3];

    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord Q_ONE = 32'sd65536;

    // Register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        t_coord surf_x;
        t_coord surf_y;
        t_coord surf_z;
        t_coord corner_x;
        t_coord corner_y;
        t_coord corner_z;
        logic   in_box;
    } t_query_result;

    // Box registers, nearest-point predictor and the queue of awaited results
    class box_query_predictor;
        t_coord box_lo [3];
        t_coord box_hi [3];
        t_query_result awaited_q [$];
        int mismatches;

        function new();
            for (int a = 0; a < 3; a++) begin
                box_lo[a] = '0;
                box_hi[a] = '0;
            end
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, t_coord value);
            case (idx)
                REG_MIN_X: box_lo[0] = value;
                REG_MIN_Y: box_lo[1] = value;
                REG_MIN_Z: box_lo[2] = value;
                REG_MAX_X: box_hi[0] = value;
                REG_MAX_Y: box_hi[1] = value;
                REG_MAX_Z: box_hi[2] = value;
                default: ;
            endcase
        endfunction

        // Called on each accepted sample transfer
        function void note_sample(t_coord3 p);
            logic signed [COORD_W+1:0] p_w, lo_w, hi_w, face_w, diff_w;
            logic [COORD_W+1:0] gap_to_face [3];
            t_coord surf [3];
            t_coord face [3];
            logic outside;
            t_query_result want;
            outside = 1'b0;
            for (int a = 0; a < 3; a++) begin
                p_w = p[a];
                lo_w = box_lo[a];
                hi_w = box_hi[a];
                // corner side: max only when strictly above the midpoint (exact, widened)
                face[a] = (p_w + p_w > lo_w + hi_w) ? box_hi[a] : box_lo[a];
                surf[a] = p[a];
                if (p[a] < box_lo[a]) begin
                    surf[a] = box_lo[a];
                    outside = 1'b1;
                end else if (p[a] > box_hi[a]) begin
                    surf[a] = box_hi[a];
                    outside = 1'b1;
                end
                face_w = face[a];
                diff_w = p_w - face_w;
                gap_to_face[a] = (diff_w < 0) ? -diff_w : diff_w;
            end
            // inside: move one coordinate onto the nearest face, ties go to the later axis
            if (!outside) begin
                if (gap_to_face[0] < gap_to_face[1]) begin
                    if (gap_to_face[0] < gap_to_face[2])
                        surf[0] = face[0];
                    else
                        surf[2] = face[2];
                end else if (gap_to_face[1] < gap_to_face[2]) begin
                    surf[1] = face[1];
                end else begin
                    surf[2] = face[2];
                end
            end
            want.surf_x = surf[0];
            want.surf_y = surf[1];
            want.surf_z = surf[2];
            want.corner_x = face[0];
            want.corner_y = face[1];
            want.corner_z = face[2];
            want.in_box = !outside;
            awaited_q.push_back(want);
        endfunction

        task report_mismatch(string what, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
            $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
            mismatches++;
        endtask

        // Called on each accepted result transfer
        task check_result(t_query_result got);
            t_query_result want;
            if (awaited_q.size() == 0) begin
                report_mismatch("unawaited result surface_x", got.surf_x, '0);
                return;
            end
            want = awaited_q.pop_front();
            if (got.surf_x !== want.surf_x)
                report_mismatch("surface_x", got.surf_x, want.surf_x);
            if (got.surf_y !== want.surf_y)
                report_mismatch("surface_y", got.surf_y, want.surf_y);
            if (got.surf_z !== want.surf_z)
                report_mismatch("surface_z", got.surf_z, want.surf_z);
            if (got.corner_x !== want.corner_x)
                report_mismatch("corner_x", got.corner_x, want.corner_x);
            if (got.corner_y !== want.corner_y)
                report_mismatch("corner_y", got.corner_y, want.corner_y);
            if (got.corner_z !== want.corner_z)
                report_mismatch("corner_z", got.corner_z, want.corner_z);
            if (got.in_box !== want.in_box)
                report_mismatch("is_inside", got.in_box, want.in_box);
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    t_coord               i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    t_coord               i_sample_x = '0;
    t_coord               i_sample_y = '0;
    t_coord               i_sample_z = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    t_coord               o_surface_x, o_surface_y, o_surface_z;
    t_coord               o_corner_x, o_corner_y, o_corner_z;
    logic                 o_is_inside;

    // idle control, changed between phases
    bit send_gaps_on = 1'b1;
    bit take_gaps_on = 1'b1;

    box_query_predictor query_pred;

    box_nearest_point_query_core #(
        .COORD_WIDTH(COORD_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .i_sample_z  (i_sample_z),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_surface_x (o_surface_x),
        .o_surface_y (o_surface_y),
        .o_surface_z (o_surface_z),
        .o_corner_x  (o_corner_x),
        .o_corner_y  (o_corner_y),
        .o_corner_z  (o_corner_z),
        .o_is_inside (o_is_inside)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_coord3 pt(t_coord x, t_coord y, t_coord z);
        t_coord3 p;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        return p;
    endfunction

    function automatic t_coord sat(longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return t_coord'(v);
    endfunction

    // Random box; kind picks small, arbitrary, inverted, flat, full range or edge-hugging
    function automatic void draw_box(int kind, output t_coord3 lo, output t_coord3 hi);
        longint center_l, half_l, span_l;
        t_coord a_c, b_c;
        int flat_axis;
        flat_axis = $urandom_range(0, 2);
        for (int a = 0; a < 3; a++) begin
            center_l = t_coord'($urandom);
            if ($urandom_range(0, 1))
                center_l = center_l >>> 12;
            half_l = $urandom_range(0, 1 << 22);
            span_l = $urandom_range(0, 1 << 16);
            a_c = t_coord'($urandom);
            b_c = t_coord'($urandom);
            lo[a] = sat(center_l - half_l);
            hi[a] = sat(center_l + half_l);
            case (kind)
                1: begin
                    lo[a] = a_c;
                    hi[a] = b_c;
                end
                2: begin
                    lo[a] = (a_c > b_c) ? a_c : b_c;
                    hi[a] = (a_c > b_c) ? b_c : a_c;
                end
                3: if (a == flat_axis) begin
                    lo[a] = a_c;
                    hi[a] = a_c;
                end
                4: if (a != flat_axis || $urandom_range(0, 1)) begin
                    lo[a] = COORD_MIN;
                    hi[a] = COORD_MAX;
                end
                5: if ($urandom_range(0, 1)) begin
                    lo[a] = COORD_MIN;
                    hi[a] = sat(COORD_MIN + span_l);
                end else begin
                    lo[a] = sat(COORD_MAX - span_l);
                    hi[a] = COORD_MAX;
                end
                default: ;
            endcase
        end
    endfunction

    // One coordinate: inside, near a bound, near the midpoint, anywhere, or an extreme
    function automatic t_coord pick_coord(t_coord lo, t_coord hi);
        longint lo_l, hi_l, span_l;
        int sel;
        lo_l = lo;
        hi_l = hi;
        sel = $urandom_range(0, 99);
        if (sel < 45 && lo_l <= hi_l) begin
            span_l = hi_l - lo_l;
            return t_coord'(lo_l + longint'({32'd0, $urandom} % (span_l + 1)));
        end
        if (sel < 60)
            return sat(((sel % 2) ? hi_l : lo_l) + int'($urandom_range(0, 4)) - 2);
        if (sel < 70)
            return sat(((lo_l + hi_l) >>> 1) + int'($urandom_range(0, 2)) - 1);
        if (sel < 90)
            return t_coord'($urandom);
        case ($urandom_range(0, 3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic t_coord3 draw_sample(t_coord3 lo, t_coord3 hi);
        t_coord3 p;
        longint offs;
        // same offset from a face on every axis, to hit the tie rules
        if ($urandom_range(0, 99) < 12) begin
            offs = $urandom_range(0, 1000);
            for (int a = 0; a < 3; a++)
                p[a] = $urandom_range(0, 1) ? sat(longint'(lo[a]) + offs)
                                            : sat(longint'(hi[a]) - offs);
        end else begin
            for (int a = 0; a < 3; a++)
                p[a] = pick_coord(lo[a], hi[a]);
        end
        return p;
    endfunction

    // Sample transfer: optional gap, then hold valid until accepted
    task automatic push_sample(t_coord3 p);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_x <= p[0];
        i_sample_y <= p[1];
        i_sample_z <= p[2];
        do @(posedge i_clk); while (o_ready !== 1'b1);
        query_pred.note_sample(p);
    endtask

    // Stop sending and wait until every result has been taken
    task automatic close_phase();
        i_valid <= 1'b0;
        while (query_pred.awaited_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Back-to-back register writes; spare indexes go last so aliasing would show
    task automatic load_box(t_coord3 lo, t_coord3 hi, bit with_spare);
        logic [CFG_IDX_W-1:0] idx_list [8];
        t_coord val_list [8];
        int n;
        idx_list[0] = REG_MIN_X;  val_list[0] = lo[0];
        idx_list[1] = REG_MIN_Y;  val_list[1] = lo[1];
        idx_list[2] = REG_MIN_Z;  val_list[2] = lo[2];
        idx_list[3] = REG_MAX_X;  val_list[3] = hi[0];
        idx_list[4] = REG_MAX_Y;  val_list[4] = hi[1];
        idx_list[5] = REG_MAX_Z;  val_list[5] = hi[2];
        idx_list[6] = IDX_SPARE_LO;
        val_list[6] = t_coord'($urandom);
        idx_list[7] = IDX_SPARE_HI;
        val_list[7] = t_coord'($urandom);
        n = with_spare ? 8 : 6;
        for (int k = 0; k < n; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx_list[k];
            i_cfg_data <= val_list[k];
            @(posedge i_clk);
            query_pred.set_reg(idx_list[k], val_list[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Result side: random stall, then take one transfer and check it
    initial begin : result_sink
        int gap;
        t_query_result got;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = take_gaps_on ? $urandom_range(0, 9) : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got.surf_x = o_surface_x;
            got.surf_y = o_surface_y;
            got.surf_z = o_surface_z;
            got.corner_x = o_corner_x;
            got.corner_y = o_corner_y;
            got.corner_z = o_corner_z;
            got.in_box = o_is_inside;
            query_pred.check_result(got);
        end
    end

    // Main sequence
    initial begin : stimulus
        t_coord3 lo, hi;
        query_pred = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset box is a single point at the origin
        push_sample(pt('0, '0, '0));
        push_sample(pt(Q_ONE, -Q_ONE, 32'sd1));
        push_sample(pt(COORD_MIN, COORD_MAX, '1));
        close_phase();

        // symmetric box of half size 4.0: face choice, ties, boundary, clamping
        load_box(pt(-4 * Q_ONE, -4 * Q_ONE, -4 * Q_ONE),
                 pt(4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE), 1'b1);
        push_sample(pt('0, '0, '0));
        push_sample(pt(Q_ONE, Q_ONE, 3 * Q_ONE));
        push_sample(pt(3 * Q_ONE, 3 * Q_ONE, '0));
        push_sample(pt(3 * Q_ONE, '0, 3 * Q_ONE));
        push_sample(pt(3 * Q_ONE, '0, '0));
        push_sample(pt('0, -3 * Q_ONE, '0));
        push_sample(pt(4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE));
        push_sample(pt(-4 * Q_ONE, -4 * Q_ONE, -4 * Q_ONE));
        push_sample(pt(4 * Q_ONE + 1, '0, '0));
        push_sample(pt('0, -4 * Q_ONE - 1, '0));
        push_sample(pt(COORD_MAX, COORD_MIN, COORD_MAX));
        push_sample(pt(COORD_MIN, COORD_MIN, COORD_MIN));
        push_sample(pt(COORD_MAX, COORD_MAX, COORD_MAX));
        push_sample(pt('1, '1, '1));
        push_sample(pt(32'sh5555_5555, t_coord'(32'hAAAA_AAAA), 32'sd1));
        close_phase();

        // inverted box: nothing is inside
        load_box(pt(5 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE),
                 pt(-5 * Q_ONE, -5 * Q_ONE, -5 * Q_ONE), 1'b0);
        push_sample(pt('0, '0, '0));
        push_sample(pt(6 * Q_ONE, -6 * Q_ONE, '0));
        push_sample(pt(5 * Q_ONE, -5 * Q_ONE, 5 * Q_ONE));
        close_phase();

        // full-range box: midpoint sum is -1, needs the widened compare
        load_box(pt(COORD_MIN, COORD_MIN, COORD_MIN),
                 pt(COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
        push_sample(pt('0, '1, 32'sd1));
        push_sample(pt(COORD_MIN, COORD_MAX, '0));
        close_phase();

        // random phases, each with its own box and idle pattern
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            draw_box(ph % 6, lo, hi);
            load_box(lo, hi, (ph % 3) == 0);
            send_gaps_on = (ph % 4 == 0) || (ph % 4 == 2);
            take_gaps_on = (ph % 4 == 0) || (ph % 4 == 1);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                push_sample(draw_sample(lo, hi));
            close_phase();
        end

        repeat (10) @(posedge i_clk);
        if (query_pred.mismatches == 0)
            $display("tb_box_nearest_point_query_core OK");
        else
            $display("tb_box_nearest_point_query_core NOT OK");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #10_000_000;
        $display("tb_box_nearest_point_query_core NOT OK");
        $finish;
    end

endmodule
